// ===== rtl/core/route_record_table_top_defines.svh =====
// assertion macros shared by the rtl
`ifndef ROUTE_RECORD_TABLE_TOP_DEFINES_SVH
`define ROUTE_RECORD_TABLE_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RRT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RRT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rrt_pkg.sv =====
// ---------------------------------------------------------------------------
// rrt_pkg
// types and constants of the route record table
// ---------------------------------------------------------------------------
`default_nettype none
package rrt_pkg;
    localparam int TableDepth  = 8;
    localparam int IdxW        = $clog2(TableDepth);
    localparam int CntW        = $clog2(TableDepth + 1);
    localparam int NameChars   = 14;
    localparam int NumberChars = 9;

    typedef enum logic [3:0] {
        ACT_ADD = 4'd0, ACT_DEL = 4'd1, ACT_SORT = 4'd2, ACT_LIST = 4'd3,
        ACT_FIND_S = 4'd4, ACT_FIND_F = 4'd5, ACT_FIND_N = 4'd6,
        ACT_CHG_S = 4'd7, ACT_CHG_F = 4'd8, ACT_CHG_N = 4'd9
    } action_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_BAD_POS = 3'd3,
        ST_NOT_FOUND = 3'd4, ST_TAKEN = 3'd5
    } status_t;

    typedef struct packed {
        logic [55:0] sh;
        logic [55:0] sl;
        logic [55:0] fh;
        logic [55:0] fl;
        logic [63:0] nh;
        logic [7:0]  nl;
    } rec_t;

    typedef struct packed {
        logic [3:0] action;
        logic [3:0] position;
        rec_t       rec;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  pos;
        rec_t        rec;
        logic        last;
    } res_t;

    // datapath commands from the controller
    typedef enum logic [3:0] {
        DC_NONE, DC_LOAD, DC_RD_A, DC_RD_B, DC_WR_APPEND, DC_WR_FIELD,
        DC_SHIFT, DC_SWAP_A, DC_SWAP_B, DC_DEC_CNT
    } dcmd_t;

    typedef struct packed {
        dcmd_t          cmd;
        logic [IdxW-1:0] ia;
        logic [IdxW-1:0] ib;
    } ctl_t;

    typedef struct packed {
        logic [3:0]      action;
        logic [3:0]      position;
        logic [CntW-1:0] count;
        logic            a_gt_b;
        logic            hit;
        logic            later_hit;
    } stat_t;

    // cut a zero padded string at its first zero byte
    function automatic logic [55:0] canon56(input logic [55:0] w, input logic prev_end,
                                            input int first, input int limit,
                                            output logic ended);
        logic e;
        logic [55:0] r;
        e = prev_end;
        r = '0;
        for (int b = 0; b < 7; b++) begin
            if (e || (first + b >= limit) || w[8*(6-b) +: 8] == 8'd0) e = 1'b1;
            else r[8*(6-b) +: 8] = w[8*(6-b) +: 8];
        end
        ended = e;
        return r;
    endfunction

    function automatic rec_t canon(input rec_t i);
        rec_t r;
        logic e;
        logic [55:0] t;
        r = '0;
        r.sh = canon56(i.sh, 1'b0, 0, NameChars, e);
        r.sl = canon56(i.sl, e, 7, NameChars, e);
        r.fh = canon56(i.fh, 1'b0, 0, NameChars, e);
        r.fl = canon56(i.fl, e, 7, NameChars, e);
        t = canon56(i.nh[63:8], 1'b0, 0, NumberChars, e);
        r.nh[63:8] = t;
        if (!e && (7 < NumberChars) && i.nh[7:0] != 8'd0) r.nh[7:0] = i.nh[7:0];
        else e = 1'b1;
        if (!e && (8 < NumberChars)) r.nl = i.nl;
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/rrt_ctrl.sv =====
// ---------------------------------------------------------------------------
// rrt_ctrl
// sequencer for add, delete, sort, list, search and change
// ---------------------------------------------------------------------------
`default_nettype none
module rrt_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [2:0]         out_status,
    output logic               out_has_rec,
    output logic               out_last,
    output rrt_pkg::ctl_t      ctl,
    input  wire rrt_pkg::stat_t st
);
    import rrt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_DEC = 8'b00000010, S_RD = 8'b00000100,
        S_CMP = 8'b00001000, S_EMIT = 8'b00010000, S_SWAP = 8'b00100000,
        S_SHIFT = 8'b01000000, S_FLUSH = 8'b10000000
    } state_t;

    state_t          state_reg, state_next;
    logic [IdxW:0]   i_reg, i_next, j_reg, j_next;
    logic            found_reg, found_next;
    logic [2:0]      stat_reg, stat_next;
    logic            rec_reg, rec_next, last_reg, last_next, ov_reg, ov_next;

    logic [IdxW:0] n_ext;
    logic          rd_phase_reg, rd_phase_next;
    assign n_ext = (IdxW+1)'(st.count);

    assign in_ready    = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid   = ov_reg;
    assign out_status  = stat_reg;
    assign out_has_rec = rec_reg;
    assign out_last    = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            rd_phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            rd_phase_reg <= rd_phase_next;
        end
        i_reg <= i_next; j_reg <= j_next; found_reg <= found_next;
        stat_reg <= stat_next; rec_reg <= rec_next; last_reg <= last_next;
    end

    task automatic emit(input logic [2:0] s, input logic r, input logic l);
        begin
            ov_next = 1'b1; stat_next = s; rec_next = r; last_next = l;
        end
    endtask

    always_comb begin
        state_next = state_reg; i_next = i_reg; j_next = j_reg;
        found_next = found_reg; stat_next = stat_reg; rec_next = rec_reg;
        last_next = last_reg; rd_phase_next = rd_phase_reg;
        ov_next = ov_reg && !out_ready;
        ctl = '{cmd: DC_NONE, ia: i_reg[IdxW-1:0], ib: j_reg[IdxW-1:0]};
        case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    ctl.cmd = DC_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                state_next = S_IDLE;
                i_next = '0; j_next = '0; found_next = 1'b0;
                if (st.action > ACT_CHG_N) begin
                    state_next = S_IDLE;
                end else if (st.action == ACT_ADD) begin
                    if (n_ext >= (IdxW+1)'(TableDepth)) emit(ST_FULL, 1'b0, 1'b1);
                    else begin
                        ctl.cmd = DC_WR_APPEND;
                        ctl.ia = st.count[IdxW-1:0];
                        emit(ST_OK, 1'b1, 1'b1);
                    end
                end else if (n_ext == '0) begin
                    emit(ST_EMPTY, 1'b0, 1'b1);
                end else if (st.action == ACT_DEL || st.action >= ACT_CHG_S) begin
                    if (st.position == 4'd0 || 5'(st.position) > 5'(n_ext))
                        emit(ST_BAD_POS, 1'b0, 1'b1);
                    else if (st.action == ACT_CHG_N) begin
                        state_next = S_RD;
                    end else if (st.action == ACT_DEL) begin
                        emit(ST_OK, 1'b1, 1'b1);
                        i_next = (IdxW+1)'(st.position - 4'd1);
                        state_next = S_SHIFT;
                    end else begin
                        ctl.cmd = DC_WR_FIELD;
                        emit(ST_OK, 1'b1, 1'b1);
                    end
                end else if (st.action == ACT_SORT) begin
                    j_next = (IdxW+1)'(1);
                    // a single record is already in order
                    if (n_ext > (IdxW+1)'(1)) state_next = S_RD;
                    else emit(ST_OK, 1'b0, 1'b1);
                end else begin
                    state_next = S_RD;
                end
                rd_phase_next = 1'b0;
            end
            S_RD: begin
                // read operands a=i and b=j (b is used by sort only)
                ctl.cmd = rd_phase_reg ? DC_RD_B : DC_RD_A;
                rd_phase_next = !rd_phase_reg;
                if (rd_phase_reg) state_next = S_CMP;
            end
            S_CMP: begin
                if (st.action == ACT_SORT) begin
                    state_next = st.a_gt_b ? S_SWAP : S_EMIT;
                end else if (st.action == ACT_CHG_N) begin
                    if (st.hit) begin
                        emit(ST_TAKEN, 1'b0, 1'b1);
                        state_next = S_FLUSH;
                    end else if (i_reg + 1'b1 >= n_ext) begin
                        ctl.cmd = DC_WR_FIELD;
                        emit(ST_OK, 1'b1, 1'b1);
                        state_next = S_FLUSH;
                    end else begin
                        i_next = i_reg + 1'b1;
                        state_next = S_RD;
                    end
                end else if (!ov_reg || out_ready) begin
                    // search or list visit of entry i
                    if (st.hit) begin
                        found_next = 1'b1;
                        // last hit when no later entry matches
                        emit(ST_OK, 1'b1, !st.later_hit);
                    end else if (i_reg + 1'b1 >= n_ext && !found_reg) begin
                        emit(ST_NOT_FOUND, 1'b0, 1'b1);
                    end
                    if (i_reg + 1'b1 >= n_ext) state_next = S_FLUSH;
                    else begin
                        i_next = i_reg + 1'b1;
                        state_next = st.hit ? S_EMIT : S_RD;
                    end
                end
            end
            S_SWAP: begin
                ctl.cmd = rd_phase_reg ? DC_SWAP_B : DC_SWAP_A;
                rd_phase_next = !rd_phase_reg;
                if (rd_phase_reg) state_next = S_EMIT;
            end
            S_EMIT: begin
                if (st.action == ACT_SORT) begin
                    if (j_reg + 1'b1 < n_ext) begin
                        j_next = j_reg + 1'b1;
                        state_next = S_RD;
                    end else if (i_reg + 2'd2 < n_ext) begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + 2'd2;
                        state_next = S_RD;
                    end else if (!ov_reg || out_ready) begin
                        emit(ST_OK, 1'b0, 1'b1);
                        state_next = S_FLUSH;
                    end
                end else begin
                    state_next = S_RD;
                end
            end
            S_SHIFT: begin
                if (i_reg + 1'b1 < n_ext) begin
                    ctl.cmd = DC_SHIFT;
                    i_next = i_reg + 1'b1;
                end else begin
                    ctl.cmd = DC_DEC_CNT;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

`include "route_record_table_top_defines.svh"
    `RRT_ASSERT_IMP(a_busy_no_accept, state_reg != S_IDLE, !in_ready, "accept while busy")
    `RRT_ASSERT_NXT(a_hold_out, out_valid && !out_ready, out_valid, "result dropped")
    `RRT_ASSERT_IMP(a_idx_range, state_reg == S_SHIFT, i_reg < n_ext, "shift index out of range")
endmodule
`default_nettype wire

// ===== rtl/core/rrt_dp.sv =====
// ---------------------------------------------------------------------------
// rrt_dp
// record storage, operand registers and compare logic
// ---------------------------------------------------------------------------
`default_nettype none
module rrt_dp (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire rrt_pkg::item_t item_in,
    input  wire rrt_pkg::ctl_t  ctl,
    output rrt_pkg::stat_t      st,
    input  wire logic           res_load,
    input  wire logic           res_take,
    output rrt_pkg::rec_t       res_rec,
    output logic [3:0]          res_pos
);
    import rrt_pkg::*;

    rec_t            tab_reg [TableDepth];
    item_t           itm_reg;
    rec_t            a_reg, b_reg;
    logic [IdxW-1:0] ai_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    rec_t            r_reg;
    logic [3:0]      rp_reg;
    logic [IdxW-1:0] pidx;
    rec_t            chg;
    logic [TableDepth-1:0] later_vec;

    assign pidx = itm_reg.position[IdxW-1:0] - 1'b1;

    always_comb begin
        chg = tab_reg[pidx];
        case (itm_reg.action)
            ACT_CHG_S: begin chg.sh = itm_reg.rec.sh; chg.sl = itm_reg.rec.sl; end
            ACT_CHG_F: begin chg.fh = itm_reg.rec.fh; chg.fl = itm_reg.rec.fl; end
            default:   begin chg.nh = itm_reg.rec.nh; chg.nl = itm_reg.rec.nl; end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (ctl.cmd == DC_WR_APPEND) cnt_next = cnt_reg + 1'b1;
        if (ctl.cmd == DC_DEC_CNT)   cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) cnt_reg <= '0;
        else          cnt_reg <= cnt_next;
        case (ctl.cmd)
            DC_LOAD:      itm_reg <= '{action: item_in.action, position: item_in.position,
                                       rec: canon(item_in.rec)};
            DC_RD_A:      begin a_reg <= tab_reg[ctl.ia]; ai_reg <= ctl.ia; end
            DC_RD_B:      b_reg <= tab_reg[ctl.ib];
            DC_WR_APPEND: tab_reg[ctl.ia] <= itm_reg.rec;
            DC_WR_FIELD:  tab_reg[pidx] <= chg;
            DC_SHIFT:     tab_reg[ctl.ia] <= tab_reg[ctl.ia + 1'b1];
            DC_SWAP_A:    tab_reg[ctl.ia] <= b_reg;
            DC_SWAP_B:    begin tab_reg[ctl.ib] <= a_reg; a_reg <= b_reg; end
            default: ;
        endcase
        if (res_load) begin
            case (ctl.cmd)
                DC_WR_APPEND: begin r_reg <= itm_reg.rec; rp_reg <= 4'(cnt_reg) + 4'd1; end
                DC_WR_FIELD:  begin r_reg <= chg; rp_reg <= itm_reg.position; end
                default: begin
                    if (itm_reg.action == ACT_DEL) begin
                        r_reg <= tab_reg[pidx]; rp_reg <= itm_reg.position;
                    end else begin
                        r_reg <= a_reg; rp_reg <= 4'(ai_reg) + 4'd1;
                    end
                end
            endcase
        end
    end

    assign res_rec = res_take ? r_reg : '0;
    assign res_pos = res_take ? rp_reg : 4'd0;

    // matches among the held records after the one in a_reg
    always_comb begin
        for (int k = 0; k < TableDepth; k++) begin
            case (itm_reg.action)
                ACT_LIST:   later_vec[k] = 1'b1;
                ACT_FIND_S: later_vec[k] = tab_reg[k].sh == itm_reg.rec.sh &&
                                           tab_reg[k].sl == itm_reg.rec.sl;
                ACT_FIND_F: later_vec[k] = tab_reg[k].fh == itm_reg.rec.fh &&
                                           tab_reg[k].fl == itm_reg.rec.fl;
                default:    later_vec[k] = tab_reg[k].nh == itm_reg.rec.nh &&
                                           tab_reg[k].nl == itm_reg.rec.nl;
            endcase
            if (k <= int'(ai_reg) || k >= int'(cnt_reg)) later_vec[k] = 1'b0;
        end
    end

    always_comb begin
        st.action    = itm_reg.action;
        st.position  = itm_reg.position;
        st.count     = cnt_reg;
        st.a_gt_b    = {a_reg.sh, a_reg.sl} > {b_reg.sh, b_reg.sl};
        st.later_hit = |later_vec;
        case (itm_reg.action)
            ACT_LIST:   st.hit = 1'b1;
            ACT_FIND_S: st.hit = a_reg.sh == itm_reg.rec.sh && a_reg.sl == itm_reg.rec.sl;
            ACT_FIND_F: st.hit = a_reg.fh == itm_reg.rec.fh && a_reg.fl == itm_reg.rec.fl;
            default:    st.hit = a_reg.nh == itm_reg.rec.nh && a_reg.nl == itm_reg.rec.nl;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/route_record_table_top.sv =====
// ---------------------------------------------------------------------------
// route_record_table_top
// Route record table: holds up to eight records (start, finish, route number)
// and answers one command per input item, one item in work at a time; action
// codes above 9 are dropped with no answer. Add, start or finish change and
// error answers found at decode are raised from the decode state, and the
// next item can be taken the cycle after the result is taken. Delete then
// shifts later records at one record a cycle and then lowers the count. List
// and search read each record in turn and report each match; a number change
// scans the records for the new number before it writes. Sort runs the
// exchange sort as n(n-1)/2 compare steps, each followed by a swap when the
// pair is out of order. The sequencer walks one record at a time, and a
// waiting result holds it and the input until taken.
// ---------------------------------------------------------------------------
`default_nettype none
module route_record_table_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // action[3:0], position[7:4], start_high, start_low, finish_high,
    // finish_low, number_high, number_low
    input  wire logic [303:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[2:0], position_res[6:3], start_high_res, start_low_res,
    // finish_high_res, finish_low_res, number_high_res, number_low_res, pad
    output logic [303:0]      m_tdata,
    output logic              m_tlast
);
    import rrt_pkg::*;

    ctl_t  ctl;
    stat_t st;
    item_t item_in;
    rec_t  res_rec;
    logic [3:0] res_pos;
    logic [2:0] status;
    logic has_rec, ov, ld;

    assign item_in.action   = s_tdata[3:0];
    assign item_in.position = s_tdata[7:4];
    assign item_in.rec.sh   = s_tdata[63:8];
    assign item_in.rec.sl   = s_tdata[119:64];
    assign item_in.rec.fh   = s_tdata[175:120];
    assign item_in.rec.fl   = s_tdata[231:176];
    assign item_in.rec.nh   = s_tdata[295:232];
    assign item_in.rec.nl   = s_tdata[303:296];

    rrt_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(ov), .out_ready(m_tready), .out_status(status),
        .out_has_rec(has_rec), .out_last(m_tlast), .ctl, .st
    );

    // capture result record when a new result is raised
    assign ld = !ov || m_tready;

    rrt_dp u_dp (
        .aclk, .aresetn, .item_in, .ctl, .st, .res_load(ld),
        .res_take(has_rec), .res_rec, .res_pos
    );

    assign m_tvalid = ov;
    assign m_tdata  = {1'b0, res_rec.nl, res_rec.nh, res_rec.fl, res_rec.fh,
                       res_rec.sl, res_rec.sh, res_pos, status};

`include "route_record_table_top_defines.svh"
    `RRT_ASSERT_NXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `RRT_ASSERT_IMP(a_no_accept_pending, m_tvalid, !s_tready, "input accepted while a result waits")
endmodule
`default_nettype wire
